/* rtl/sorted_interval_ledger_core_defines.svh */
// assertion macros for the sorted interval ledger checker
// no dependencies; included by the checker file
`ifndef SORTED_INTERVAL_LEDGER_CORE_DEFINES_SVH
`define SORTED_INTERVAL_LEDGER_CORE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define SIL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sil_pkg.sv */
// shared types, constants and compare functions for the sorted interval ledger
// no dependencies
package sil_pkg;

  localparam int CAPACITY      = 32;
  localparam int MAX_OUT       = 32;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int FIELD_W       = 32;
  localparam int ACTION_W      = 2;
  localparam int STATUS_W      = 2;
  localparam int IDX_W         = 5;
  localparam int ENTRY_COUNT_W = 6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACCEPT = 2'd0,
    ACT_DUMP   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_RSVD   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_OVERLAP = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_HOLD = 5'b00001,
    OP_CMP  = 5'b00010,
    OP_INS  = 5'b00100,
    OP_ROT  = 5'b01000,
    OP_CLR  = 5'b10000
  } cell_op_e;

  typedef struct packed {
    logic [FIELD_W-1:0] worker;
    logic [FIELD_W-1:0] state_id;
    logic [FIELD_W-1:0] iter_begin;
    logic [FIELD_W-1:0] iter_end;
  } rec_t;

  typedef struct packed {
    cell_op_e op;
    rec_t     new_rec;
  } cell_ctl_t;

  typedef struct packed {
    logic occ;
    logic ge;
    rec_t rec;
  } cell_link_t;

  // a sorts strictly before b: state, begin, end, then worker
  function automatic logic rec_before(rec_t a, rec_t b);
    logic r;
    if (a.state_id != b.state_id) begin
      r = a.state_id < b.state_id;
    end else if (a.iter_begin != b.iter_begin) begin
      r = a.iter_begin < b.iter_begin;
    end else if (a.iter_end != b.iter_end) begin
      r = a.iter_end < b.iter_end;
    end else begin
      r = a.worker < b.worker;
    end
    return r;
  endfunction

  // same state and half-open intervals intersect
  function automatic logic rec_overlap(rec_t a, rec_t b);
    return (a.state_id == b.state_id) && (b.iter_begin < a.iter_end) &&
           (a.iter_begin < b.iter_end);
  endfunction

endpackage

/* rtl/sil_cell.sv */
// one slot of the ordered record chain: compare, shift-insert, rotate, clear
// depends on sil_pkg
module sil_cell import sil_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctl_t  ctl_i,
  input  cell_link_t left_i,
  input  cell_link_t right_i,
  input  rec_t       wrap_i,
  output cell_link_t link_o,
  output logic       ovl_o
);

  logic occ_q, occ_d;
  logic ge_q, ge_d;
  logic ovl_q, ovl_d;
  rec_t rec_q, rec_d;

  always_comb begin
    occ_d = occ_q;
    ge_d  = ge_q;
    ovl_d = ovl_q;
    rec_d = rec_q;
    case (ctl_i.op)
      OP_CMP: begin
        ge_d  = occ_q & rec_before(ctl_i.new_rec, rec_q);
        ovl_d = occ_q & rec_overlap(ctl_i.new_rec, rec_q);
      end
      OP_INS: begin
        if (left_i.occ && left_i.ge) begin
          rec_d = left_i.rec;
          occ_d = 1'b1;
        end else if ((occ_q && ge_q) || (!occ_q && left_i.occ)) begin
          rec_d = ctl_i.new_rec;
          occ_d = 1'b1;
        end
      end
      OP_ROT: begin
        if (right_i.occ) begin
          rec_d = right_i.rec;
        end else if (occ_q) begin
          rec_d = wrap_i;
        end
      end
      OP_CLR: begin
        occ_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      ge_q  <= 1'b0;
      ovl_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      ge_q  <= ge_d;
      ovl_q <= ovl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign link_o = '{occ: occ_q, ge: ge_q, rec: rec_q};
  assign ovl_o  = ovl_q;

endmodule

/* rtl/sorted_interval_ledger_core.sv */
// channel  dir  handshake                payload
// in       in   in_valid_i / in_ready_o   action, worker, state_id, iter_begin, iter_end,
//                                         result_ok
// out      out  out_valid_o / out_ready_i status, has_entry, entry_index, out_worker,
//                                         out_state_id, out_begin, out_end, entry_count, last
//
// one word at a time: accept, clear and unused codes reach the output register through
// intake, a parallel compare in all cells and commit; dump then rotates the n stored
// records out of cell 0 of the chain, one record a cycle while the output is free
// the output register frees the next intake while a result waits; a stalled output holds
// the dump rotation; reset empties the chain, no clearing pass
// depends on sil_pkg and sil_cell
module sorted_interval_ledger_core import sil_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ACTION_W-1:0]      action_i,
  input  logic [FIELD_W-1:0]       worker_i,
  input  logic [FIELD_W-1:0]       state_id_i,
  input  logic [FIELD_W-1:0]       iter_begin_i,
  input  logic [FIELD_W-1:0]       iter_end_i,
  input  logic                     result_ok_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     has_entry_o,
  output logic [IDX_W-1:0]         entry_index_o,
  output logic [FIELD_W-1:0]       out_worker_o,
  output logic [FIELD_W-1:0]       out_state_id_o,
  output logic [FIELD_W-1:0]       out_begin_o,
  output logic [FIELD_W-1:0]       out_end_o,
  output logic [ENTRY_COUNT_W-1:0] entry_count_o,
  output logic                     last_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_EXEC = 4'b0100,
    S_DUMP = 4'b1000
  } state_e;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     has_entry;
    logic [IDX_W-1:0]         entry_index;
    rec_t                     rec;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     last;
  } res_t;

  state_e           state_q, state_d;
  action_e          act_q;
  rec_t             rec_q;
  logic             ok_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  cell_ctl_t        ctl;
  cell_link_t       links [CAPACITY];
  logic [CAPACITY-1:0] ovl_vec;

  logic             in_acc;
  logic             out_free;
  logic             emit;
  logic             full;
  logic             dump_emit;
  logic [CNT_W-1:0] dump_n;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left_l, right_l;
    if (i == 0) begin : g_head
      assign left_l = '{occ: 1'b1, ge: 1'b0, rec: '0};
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_l = '{occ: 1'b0, ge: 1'b0, rec: '0};
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end
    sil_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .left_i  (left_l),
      .right_i (right_l),
      .wrap_i  (links[0].rec),
      .link_o  (links[i]),
      .ovl_o   (ovl_vec[i])
    );
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign full       = (cnt_q == CNT_W'(CAPACITY));
  assign dump_n     = (int'(cnt_q) > MAX_OUT) ? CNT_W'(MAX_OUT) : cnt_q;
  assign dump_emit  = int'(k_q) < MAX_OUT;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    emit        = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;
    ctl.op      = OP_HOLD;
    ctl.new_rec = rec_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        ctl.op  = OP_CMP;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          case (act_q)
            ACT_ACCEPT: begin
              emit = 1'b1;
              if (rec_q.worker == '0 || !ok_q) begin
                res_d.status = ST_INVALID;
              end else if (full) begin
                res_d.status = ST_FULL;
              end else if (|ovl_vec) begin
                res_d.status = ST_OVERLAP;
              end else begin
                res_d.status = ST_OK;
                ctl.op       = OP_INS;
                cnt_d        = cnt_q + CNT_W'(1);
              end
            end
            ACT_DUMP: begin
              if (cnt_q == '0) begin
                emit         = 1'b1;
                res_d.status = ST_OK;
              end else begin
                k_d     = '0;
                state_d = S_DUMP;
              end
            end
            ACT_CLEAR: begin
              emit         = 1'b1;
              res_d.status = ST_OK;
              ctl.op       = OP_CLR;
              cnt_d        = '0;
            end
            default: begin
              emit         = 1'b1;
              res_d.status = ST_INVALID;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free || !dump_emit) begin
          ctl.op            = OP_ROT;
          emit              = dump_emit;
          res_d.status      = ST_OK;
          res_d.has_entry   = 1'b1;
          res_d.entry_index = IDX_W'(k_q);
          res_d.rec         = links[0].rec;
          res_d.last        = (k_q + CNT_W'(1) == dump_n);
          k_d               = k_q + CNT_W'(1);
          if (k_q + CNT_W'(1) == cnt_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    res_d.entry_count = ENTRY_COUNT_W'(cnt_d);
  end

  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q            <= action_e'(action_i);
      rec_q.worker     <= worker_i;
      rec_q.state_id   <= state_id_i;
      rec_q.iter_begin <= iter_begin_i;
      rec_q.iter_end   <= iter_end_i;
      ok_q             <= result_ok_i;
    end
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign has_entry_o    = res_q.has_entry;
  assign entry_index_o  = res_q.entry_index;
  assign out_worker_o   = res_q.rec.worker;
  assign out_state_id_o = res_q.rec.state_id;
  assign out_begin_o    = res_q.rec.iter_begin;
  assign out_end_o      = res_q.rec.iter_end;
  assign entry_count_o  = res_q.entry_count;
  assign last_o         = res_q.last;

endmodule

/* rtl/sil_chk.sv */
// port-level checks for sorted_interval_ledger_core, attached by bind
// depends on sil_pkg and sorted_interval_ledger_core_defines.svh
`include "sorted_interval_ledger_core_defines.svh"

module sil_chk import sil_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [STATUS_W-1:0]      status_o,
  input logic                     has_entry_o,
  input logic [IDX_W-1:0]         entry_index_o,
  input logic [FIELD_W-1:0]       out_worker_o,
  input logic [FIELD_W-1:0]       out_state_id_o,
  input logic [FIELD_W-1:0]       out_begin_o,
  input logic [FIELD_W-1:0]       out_end_o,
  input logic [ENTRY_COUNT_W-1:0] entry_count_o,
  input logic                     last_o
);

  // stalled output word holds
  `SIL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(out_worker_o) && $stable(last_o), "stalled output word changed")

  // record-carrying words are always ok
  `SIL_ASSERT_NOW(a_entry_ok, out_valid_o && has_entry_o, status_o == ST_OK, "record word with bad status")

  // words without a record carry zeros and close their item
  `SIL_ASSERT_NOW(a_no_entry_zero, out_valid_o && !has_entry_o, entry_index_o == '0 && out_worker_o == '0 && out_state_id_o == '0 && out_begin_o == '0 && out_end_o == '0 && last_o, "empty word not clean")

  // a full rejection reports a full table
  `SIL_ASSERT_NOW(a_full_count, out_valid_o && status_o == ST_FULL, entry_count_o == ENTRY_COUNT_W'(CAPACITY), "full status with wrong count")

  // one word at a time on the input
  `SIL_ASSERT_NEXT(a_in_busy, in_valid_i && in_ready_o, !in_ready_o, "input ready right after intake")

endmodule

bind sorted_interval_ledger_core sil_chk u_sil_chk (.*);
